@@ hw/rtl/eprs_pkg.sv @@
package eprs_pkg;

  // Request kinds
  localparam logic [1:0] FUNC_REFRESH = 2'd0;
  localparam logic [1:0] FUNC_WINDOW  = 2'd1;
  localparam logic [1:0] FUNC_SLEEP   = 2'd2;
  localparam logic [1:0] FUNC_NONE    = 2'd3;

  // Refresh modes
  localparam logic [1:0] MODE_FULL = 2'd0;
  localparam logic [1:0] MODE_HALF = 2'd1;
  localparam logic [1:0] MODE_FAST = 2'd2;
  localparam logic [1:0] MODE_BAD  = 2'd3;

  // Item kinds
  localparam logic [1:0] KIND_CMD  = 2'd0;
  localparam logic [1:0] KIND_DAT  = 2'd1;
  localparam logic [1:0] KIND_WAIT = 2'd2;

  // Config register indexes
  localparam logic [2:0] CFG_FULL_SEQ    = 3'd0;
  localparam logic [2:0] CFG_FAST_SEQ    = 3'd1;
  localparam logic [2:0] CFG_HALF_SEQ    = 3'd2;
  localparam logic [2:0] CFG_BORDER_FULL = 3'd3;
  localparam logic [2:0] CFG_BORDER_FAST = 3'd4;
  localparam logic [2:0] CFG_BORDER_HALF = 3'd5;
  localparam logic [2:0] CFG_HALF_TEMP   = 3'd6;
  localparam logic [2:0] CFG_MIRROR      = 3'd7;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 8;

  // Panel controller commands
  localparam logic [7:0] CMD_SLEEP      = 8'h10;
  localparam logic [7:0] CMD_ENTRY_MODE = 8'h11;
  localparam logic [7:0] CMD_MASTER_ACT = 8'h20;
  localparam logic [7:0] CMD_UPD_CTRL1  = 8'h21;
  localparam logic [7:0] CMD_UPD_CTRL2  = 8'h22;
  localparam logic [7:0] CMD_TEMP_WR    = 8'h1A;
  localparam logic [7:0] CMD_BORDER     = 8'h3C;
  localparam logic [7:0] CMD_RAM_XRANGE = 8'h44;
  localparam logic [7:0] CMD_RAM_YRANGE = 8'h45;
  localparam logic [7:0] CMD_RAM_XCNT   = 8'h4E;
  localparam logic [7:0] CMD_RAM_YCNT   = 8'h4F;

  // Data byte constants
  localparam logic [7:0] DAT_CTRL1_NORM = 8'h40;
  localparam logic [7:0] DAT_CTRL1_FAST = 8'h00;
  localparam logic [7:0] DM_POWER_ON    = 8'hC0;
  localparam logic [7:0] DM_POWER_OFF   = 8'h03;
  localparam logic [7:0] DM_FULL        = 8'h34;
  localparam logic [7:0] DM_HALF        = 8'hD4;
  localparam logic [7:0] DM_FAST        = 8'h1C;
  localparam logic [7:0] DM_FAST_LUT    = 8'h0C;
  localparam logic [7:0] DAT_SLEEP      = 8'h01;
  localparam logic [7:0] DAT_ENTRY_NORM = 8'h01;
  localparam logic [7:0] DAT_ENTRY_MIR  = 8'h00;

  // Reset values of the config registers
  localparam logic [7:0] RST_FULL_SEQ    = 8'hF7;
  localparam logic [7:0] RST_FAST_SEQ    = 8'hFC;
  localparam logic [7:0] RST_HALF_SEQ    = 8'hD7;
  localparam logic [7:0] RST_BORDER      = 8'hC0;
  localparam logic [7:0] RST_HALF_TEMP   = 8'h5A;

  // Script slot counter; longest script (window) has 18 slots
  localparam int SLOT_W = 5;

  typedef struct packed {
    logic [1:0] func;
    logic [1:0] refresh_mode;
    logic       power_off_after;
    logic       lut_loaded;
    logic       from_display;
    logic [9:0] win_x;
    logic [8:0] win_y;
    logic [9:0] win_w;
    logic [8:0] win_h;
  } in_req_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic       last;
    logic [1:0] mode_used;
  } out_item_t;

  // Controller -> datapath
  typedef struct packed {
    logic              load;
    logic              emit;
    logic [SLOT_W-1:0] slot;
  } eprs_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic req_void;
    logic slot_en;
    logic slot_final;
    logic out_stall;
  } eprs_sts_t;

endpackage

@@ hw/rtl/eprs_ctrl.sv @@
module eprs_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output eprs_pkg::eprs_cmd_t cmd,
  input  eprs_pkg::eprs_sts_t sts
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  state_t                      state_r, state_nxt;
  logic [eprs_pkg::SLOT_W-1:0] slot_r, slot_nxt;

  always_comb begin
    state_nxt = state_r;
    slot_nxt  = slot_r;
    cmd.load  = 1'b0;
    cmd.emit  = 1'b0;
    cmd.slot  = slot_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          slot_nxt = '0;
          if (!sts.req_void) begin
            state_nxt = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        // disabled slots are stepped over without output
        if (!sts.slot_en) begin
          slot_nxt = slot_r + 1'b1;
        end else if (!sts.out_stall) begin
          cmd.emit = 1'b1;
          if (sts.slot_final) begin
            state_nxt = ST_IDLE;
          end else begin
            slot_nxt = slot_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign in_ready = (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      slot_r  <= '0;
    end else begin
      state_r <= state_nxt;
      slot_r  <= slot_nxt;
    end
  end

endmodule

@@ hw/rtl/eprs_datapath.sv @@
module eprs_datapath #(
  parameter int PANEL_HEIGHT = 480
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  eprs_pkg::in_req_t                   in_data,
  input  logic                                cfg_we,
  input  logic [eprs_pkg::CFG_AW-1:0]         cfg_addr,
  input  logic [eprs_pkg::CFG_DW-1:0]         cfg_wdata,
  output logic                                out_valid,
  input  logic                                out_ready,
  output eprs_pkg::out_item_t                 out_data,
  input  eprs_pkg::eprs_cmd_t                 cmd,
  output eprs_pkg::eprs_sts_t                 sts
);

  // config registers
  logic [7:0] full_seq_r, fast_seq_r, half_seq_r;
  logic [7:0] border_full_r, border_fast_r, border_half_r;
  logic [7:0] half_temp_r;
  logic       mirror_r;

  // panel state
  logic pp_r, pp_nxt;
  logic ffp_r, ffp_nxt;

  // request script context
  logic [1:0]  func_r, func_nxt;
  logic [1:0]  mode_used_r, mode_used_nxt;
  logic        en_border_r, en_border_nxt;
  logic        en_temp_r, en_temp_nxt;
  logic        slp_pwr_r, slp_pwr_nxt;
  logic [7:0]  ctrl1_r, ctrl1_nxt;
  logic [7:0]  border_r, border_nxt;
  logic [7:0]  seqb_r, seqb_nxt;
  logic [15:0] xs_r, xs_nxt, xe_r, xe_nxt, yt_r, yt_nxt, yb_r, yb_nxt;

  // output register
  logic                out_valid_r, out_valid_nxt;
  eprs_pkg::out_item_t out_data_r;

  // load-time decode
  logic [1:0]  mode;
  logic [7:0]  seq, brd, dm;
  logic        ovr;
  logic [15:0] xlo, xhi;

  always_comb begin
    pp_nxt        = pp_r;
    ffp_nxt       = ffp_r;
    mode          = (in_data.refresh_mode == eprs_pkg::MODE_BAD) ? eprs_pkg::MODE_FULL
                                                               : in_data.refresh_mode;
    if (in_data.func == eprs_pkg::FUNC_REFRESH && in_data.from_display &&
        !in_data.power_off_after) begin
      if (ffp_r) begin
        mode    = eprs_pkg::MODE_FULL;
        ffp_nxt = 1'b0;
      end else if (!pp_r && full_seq_r == 8'd0) begin
        mode = eprs_pkg::MODE_HALF;
      end
    end

    if (mode == eprs_pkg::MODE_FAST) begin
      seq = fast_seq_r;
      brd = border_fast_r;
    end else if (mode == eprs_pkg::MODE_HALF) begin
      seq = (half_seq_r != 8'd0) ? half_seq_r : full_seq_r;
      brd = (border_half_r != 8'd0) ? border_half_r : border_full_r;
    end else begin
      seq = full_seq_r;
      brd = border_full_r;
    end
    ovr = (seq != 8'd0) && !in_data.lut_loaded;

    dm = (pp_r ? 8'd0 : eprs_pkg::DM_POWER_ON) |
         (in_data.power_off_after ? eprs_pkg::DM_POWER_OFF : 8'd0);
    if (mode == eprs_pkg::MODE_FULL) begin
      dm = dm | eprs_pkg::DM_FULL;
    end else if (mode == eprs_pkg::MODE_HALF) begin
      dm = dm | eprs_pkg::DM_HALF;
    end else begin
      dm = dm | (in_data.lut_loaded ? eprs_pkg::DM_FAST_LUT : eprs_pkg::DM_FAST);
    end

    func_nxt      = in_data.func;
    mode_used_nxt = (in_data.func == eprs_pkg::FUNC_REFRESH) ? mode : 2'd0;
    en_border_nxt = ovr && (brd != 8'd0);
    en_temp_nxt   = (mode == eprs_pkg::MODE_HALF);
    ctrl1_nxt     = (mode == eprs_pkg::MODE_FAST) ? eprs_pkg::DAT_CTRL1_FAST
                                                  : eprs_pkg::DAT_CTRL1_NORM;
    border_nxt    = brd;
    seqb_nxt      = ovr ? seq : dm;
    slp_pwr_nxt   = pp_r;

    if (in_data.func == eprs_pkg::FUNC_REFRESH) begin
      if (ovr) begin
        pp_nxt = (seq[1:0] != 2'd0) ? 1'b0 : !in_data.power_off_after;
      end else begin
        pp_nxt = !in_data.power_off_after;
      end
    end else if (in_data.func == eprs_pkg::FUNC_SLEEP) begin
      pp_nxt = 1'b0;
    end

    // window coordinates, 16-bit wrap
    xlo    = {6'd0, in_data.win_x};
    xhi    = xlo + {6'd0, in_data.win_w} - 16'd1;
    xs_nxt = mirror_r ? xhi : xlo;
    xe_nxt = mirror_r ? xlo : xhi;
    yb_nxt = 16'(PANEL_HEIGHT) - {7'd0, in_data.win_y} - {7'd0, in_data.win_h};
    yt_nxt = 16'(PANEL_HEIGHT) - {7'd0, in_data.win_y} - 16'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pp_r  <= 1'b0;
      ffp_r <= 1'b1;
    end else if (cmd.load) begin
      pp_r  <= pp_nxt;
      ffp_r <= ffp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r      <= func_nxt;
      mode_used_r <= mode_used_nxt;
      en_border_r <= en_border_nxt;
      en_temp_r   <= en_temp_nxt;
      slp_pwr_r   <= slp_pwr_nxt;
      ctrl1_r     <= ctrl1_nxt;
      border_r    <= border_nxt;
      seqb_r      <= seqb_nxt;
      xs_r        <= xs_nxt;
      xe_r        <= xe_nxt;
      yt_r        <= yt_nxt;
      yb_r        <= yb_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_seq_r    <= eprs_pkg::RST_FULL_SEQ;
      fast_seq_r    <= eprs_pkg::RST_FAST_SEQ;
      half_seq_r    <= eprs_pkg::RST_HALF_SEQ;
      border_full_r <= eprs_pkg::RST_BORDER;
      border_fast_r <= eprs_pkg::RST_BORDER;
      border_half_r <= eprs_pkg::RST_BORDER;
      half_temp_r   <= eprs_pkg::RST_HALF_TEMP;
      mirror_r      <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        eprs_pkg::CFG_FULL_SEQ:    full_seq_r    <= cfg_wdata;
        eprs_pkg::CFG_FAST_SEQ:    fast_seq_r    <= cfg_wdata;
        eprs_pkg::CFG_HALF_SEQ:    half_seq_r    <= cfg_wdata;
        eprs_pkg::CFG_BORDER_FULL: border_full_r <= cfg_wdata;
        eprs_pkg::CFG_BORDER_FAST: border_fast_r <= cfg_wdata;
        eprs_pkg::CFG_BORDER_HALF: border_half_r <= cfg_wdata;
        eprs_pkg::CFG_HALF_TEMP:   half_temp_r   <= cfg_wdata;
        eprs_pkg::CFG_MIRROR:      mirror_r      <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // script slot -> item
  logic [1:0] it_kind;
  logic [7:0] it_byte;
  logic       it_en, it_final;

  always_comb begin
    it_kind  = eprs_pkg::KIND_CMD;
    it_byte  = 8'd0;
    it_en    = 1'b1;
    it_final = 1'b0;
    if (func_r == eprs_pkg::FUNC_WINDOW) begin
      unique case (cmd.slot)
        5'd0:  it_byte = eprs_pkg::CMD_ENTRY_MODE;
        5'd1:  begin
          it_kind = eprs_pkg::KIND_DAT;
          it_byte = mirror_r ? eprs_pkg::DAT_ENTRY_MIR : eprs_pkg::DAT_ENTRY_NORM;
        end
        5'd2:  it_byte = eprs_pkg::CMD_RAM_XRANGE;
        5'd3:  begin it_kind = eprs_pkg::KIND_DAT; it_byte = xs_r[7:0];  end
        5'd4:  begin it_kind = eprs_pkg::KIND_DAT; it_byte = xs_r[15:8]; end
        5'd5:  begin it_kind = eprs_pkg::KIND_DAT; it_byte = xe_r[7:0];  end
        5'd6:  begin it_kind = eprs_pkg::KIND_DAT; it_byte = xe_r[15:8]; end
        5'd7:  it_byte = eprs_pkg::CMD_RAM_YRANGE;
        5'd8:  begin it_kind = eprs_pkg::KIND_DAT; it_byte = yt_r[7:0];  end
        5'd9:  begin it_kind = eprs_pkg::KIND_DAT; it_byte = yt_r[15:8]; end
        5'd10: begin it_kind = eprs_pkg::KIND_DAT; it_byte = yb_r[7:0];  end
        5'd11: begin it_kind = eprs_pkg::KIND_DAT; it_byte = yb_r[15:8]; end
        5'd12: it_byte = eprs_pkg::CMD_RAM_XCNT;
        5'd13: begin it_kind = eprs_pkg::KIND_DAT; it_byte = xs_r[7:0];  end
        5'd14: begin it_kind = eprs_pkg::KIND_DAT; it_byte = xs_r[15:8]; end
        5'd15: it_byte = eprs_pkg::CMD_RAM_YCNT;
        5'd16: begin it_kind = eprs_pkg::KIND_DAT; it_byte = yt_r[7:0];  end
        default: begin
          it_kind  = eprs_pkg::KIND_DAT;
          it_byte  = yt_r[15:8];
          it_final = 1'b1;
        end
      endcase
    end else if (func_r == eprs_pkg::FUNC_SLEEP) begin
      unique case (cmd.slot)
        5'd0: begin it_en = slp_pwr_r; it_byte = eprs_pkg::CMD_UPD_CTRL1; end
        5'd1: begin
          it_en   = slp_pwr_r;
          it_kind = eprs_pkg::KIND_DAT;
          it_byte = eprs_pkg::DAT_CTRL1_NORM;
        end
        5'd2: begin it_en = slp_pwr_r; it_byte = eprs_pkg::CMD_UPD_CTRL2; end
        5'd3: begin
          it_en   = slp_pwr_r;
          it_kind = eprs_pkg::KIND_DAT;
          it_byte = eprs_pkg::DM_POWER_OFF;
        end
        5'd4: begin it_en = slp_pwr_r; it_byte = eprs_pkg::CMD_MASTER_ACT; end
        5'd5: begin it_en = slp_pwr_r; it_kind = eprs_pkg::KIND_WAIT; end
        5'd6: it_byte = eprs_pkg::CMD_SLEEP;
        default: begin
          it_kind  = eprs_pkg::KIND_DAT;
          it_byte  = eprs_pkg::DAT_SLEEP;
          it_final = 1'b1;
        end
      endcase
    end else begin
      // refresh script; border and temperature pairs are optional
      unique case (cmd.slot)
        5'd0: it_byte = eprs_pkg::CMD_UPD_CTRL1;
        5'd1: begin it_kind = eprs_pkg::KIND_DAT; it_byte = ctrl1_r; end
        5'd2: begin it_en = en_border_r; it_byte = eprs_pkg::CMD_BORDER; end
        5'd3: begin it_en = en_border_r; it_kind = eprs_pkg::KIND_DAT; it_byte = border_r; end
        5'd4: begin it_en = en_temp_r; it_byte = eprs_pkg::CMD_TEMP_WR; end
        5'd5: begin it_en = en_temp_r; it_kind = eprs_pkg::KIND_DAT; it_byte = half_temp_r; end
        5'd6: it_byte = eprs_pkg::CMD_UPD_CTRL2;
        5'd7: begin it_kind = eprs_pkg::KIND_DAT; it_byte = seqb_r; end
        5'd8: it_byte = eprs_pkg::CMD_MASTER_ACT;
        default: begin
          it_kind  = eprs_pkg::KIND_WAIT;
          it_final = 1'b1;
        end
      endcase
    end
  end

  assign out_valid_nxt = cmd.emit | (out_valid_r & ~out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data_r.kind      <= it_kind;
      out_data_r.out_byte  <= it_byte;
      out_data_r.last      <= it_final;
      out_data_r.mode_used <= mode_used_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_data       = out_data_r;
  assign sts.req_void   = (in_data.func == eprs_pkg::FUNC_NONE);
  assign sts.slot_en    = it_en;
  assign sts.slot_final = it_final;
  assign sts.out_stall  = out_valid_r & ~out_ready;

endmodule

@@ hw/rtl/epaper_refresh_sequencer_core.sv @@
// Channel  | Direction | Signals                             | Payload
// ---------+-----------+-------------------------------------+----------------------
// request  | in        | in_valid / in_ready / in_data       | eprs_pkg::in_req_t
// item     | out       | out_valid / out_ready / out_data    | eprs_pkg::out_item_t
// config   | in        | cfg_we / cfg_addr / cfg_wdata       | 8-bit register write
//
// One request at a time: each is accepted, then, unless it is FUNC_NONE, the sequencer
// steps one script slot per cycle unless the output stalls (refresh 10, window 18,
// sleep 8 slots); skipped optional slots are stepped over too, without output.
// The item output register holds a finished item while a new request is accepted.
// out_ready low while an item is held stalls the sequencer on the current slot, unless that slot is disabled.
// Reset (rst_n low, synchronous) restores register defaults, panel off and
// first paint pending.
module epaper_refresh_sequencer_core #(
  parameter int PANEL_HEIGHT = 480
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  eprs_pkg::in_req_t           in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output eprs_pkg::out_item_t         out_data,
  input  logic                        cfg_we,
  input  logic [eprs_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [eprs_pkg::CFG_DW-1:0] cfg_wdata
);

  eprs_pkg::eprs_cmd_t cmd;
  eprs_pkg::eprs_sts_t sts;

  // sequencer: walks the script slots of the latched request
  eprs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  // datapath: config regs, panel state, request decode, slot item table,
  // output register
  eprs_datapath #(
    .PANEL_HEIGHT (PANEL_HEIGHT)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

@@ hw/rtl/eprs_checker.sv @@
module eprs_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input eprs_pkg::in_req_t   in_data,
  input logic                out_valid,
  input logic                out_ready,
  input eprs_pkg::out_item_t out_data
);

  // pending item holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("item changed while stalled");

  // mid-script item in the output register means the sequencer is busy
  a_busy_mid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last |-> !in_ready)
    else $error("request taken mid-script");

  // a real request makes the sequencer busy next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_data.func != eprs_pkg::FUNC_NONE) |=> !in_ready)
    else $error("sequencer not busy after request");

  // wait markers carry a zero byte
  a_wait_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.kind == eprs_pkg::KIND_WAIT) |-> (out_data.out_byte == 8'd0))
    else $error("wait marker with nonzero byte");

endmodule

bind epaper_refresh_sequencer_core eprs_checker u_eprs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

@@ tb/sv/eprs_tb_pkg.sv @@
package eprs_tb_pkg;
  import eprs_pkg::*;

  localparam int PANEL_ROWS = 480;
  localparam int REPORT_CAP = 40;

  // Tracks what the sequencer should emit for each accepted request.
  class panel_script_board;
    logic [7:0] full_seq    = RST_FULL_SEQ;
    logic [7:0] fast_seq    = RST_FAST_SEQ;
    logic [7:0] half_seq    = RST_HALF_SEQ;
    logic [7:0] border_full = RST_BORDER;
    logic [7:0] border_fast = RST_BORDER;
    logic [7:0] border_half = RST_BORDER;
    logic [7:0] half_temp   = RST_HALF_TEMP;
    logic       mirror      = 1'b0;
    logic       powered     = 1'b0;
    logic       first_paint = 1'b1;

    out_item_t   script[$];
    out_item_t   expected_items[$];
    int unsigned errors = 0;

    function void set_reg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] v);
      case (idx)
        CFG_FULL_SEQ:    full_seq    = v;
        CFG_FAST_SEQ:    fast_seq    = v;
        CFG_HALF_SEQ:    half_seq    = v;
        CFG_BORDER_FULL: border_full = v;
        CFG_BORDER_FAST: border_fast = v;
        CFG_BORDER_HALF: border_half = v;
        CFG_HALF_TEMP:   half_temp   = v;
        CFG_MIRROR:      mirror      = v[0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_items.size();
    endfunction

    function void add_item(logic [1:0] k, logic [7:0] b);
      out_item_t it;
      it = '0;
      it.kind = k;
      it.out_byte = b;
      script.push_back(it);
    endfunction

    // low byte first
    function void add_word(logic [15:0] v);
      add_item(KIND_DAT, v[7:0]);
      add_item(KIND_DAT, v[15:8]);
    endfunction

    function void build_refresh(logic [1:0] m, logic off, logic lut);
      logic [7:0] upd, brd, dm;
      add_item(KIND_CMD, CMD_UPD_CTRL1);
      add_item(KIND_DAT, (m == MODE_FAST) ? DAT_CTRL1_FAST : DAT_CTRL1_NORM);
      if (m == MODE_FAST) upd = fast_seq;
      else if (m == MODE_HALF && half_seq != 8'h00) upd = half_seq;
      else upd = full_seq;
      if (upd != 8'h00 && !lut) begin
        if (m == MODE_FAST) brd = border_fast;
        else if (m == MODE_HALF && border_half != 8'h00) brd = border_half;
        else brd = border_full;
        if (brd != 8'h00) begin
          add_item(KIND_CMD, CMD_BORDER);
          add_item(KIND_DAT, brd);
        end
        if (m == MODE_HALF) begin
          add_item(KIND_CMD, CMD_TEMP_WR);
          add_item(KIND_DAT, half_temp);
        end
        add_item(KIND_CMD, CMD_UPD_CTRL2);
        add_item(KIND_DAT, upd);
        add_item(KIND_CMD, CMD_MASTER_ACT);
        add_item(KIND_WAIT, 8'h00);
        // override byte with power-down bits leaves the panel off
        powered = (upd[1:0] != 2'b00) ? 1'b0 : !off;
        return;
      end
      dm = 8'h00;
      if (!powered) begin
        powered = 1'b1;
        dm |= DM_POWER_ON;
      end
      if (off) begin
        powered = 1'b0;
        dm |= DM_POWER_OFF;
      end
      case (m)
        MODE_FULL: dm |= DM_FULL;
        MODE_HALF: begin
          add_item(KIND_CMD, CMD_TEMP_WR);
          add_item(KIND_DAT, half_temp);
          dm |= DM_HALF;
        end
        default: dm |= lut ? DM_FAST_LUT : DM_FAST;
      endcase
      add_item(KIND_CMD, CMD_UPD_CTRL2);
      add_item(KIND_DAT, dm);
      add_item(KIND_CMD, CMD_MASTER_ACT);
      add_item(KIND_WAIT, 8'h00);
    endfunction

    // all window math wraps at 16 bits
    function void build_window(logic [9:0] x, logic [8:0] y, logic [9:0] w, logic [8:0] h);
      logic [15:0] xlo, xhi, xs, xe, yb, yt;
      xlo = {6'd0, x};
      xhi = xlo + {6'd0, w} - 16'd1;
      xs  = mirror ? xhi : xlo;
      xe  = mirror ? xlo : xhi;
      yb  = 16'(PANEL_ROWS) - {7'd0, y} - {7'd0, h};
      yt  = yb + {7'd0, h} - 16'd1;
      add_item(KIND_CMD, CMD_ENTRY_MODE);
      add_item(KIND_DAT, mirror ? DAT_ENTRY_MIR : DAT_ENTRY_NORM);
      add_item(KIND_CMD, CMD_RAM_XRANGE);
      add_word(xs);
      add_word(xe);
      add_item(KIND_CMD, CMD_RAM_YRANGE);
      add_word(yt);
      add_word(yb);
      add_item(KIND_CMD, CMD_RAM_XCNT);
      add_word(xs);
      add_item(KIND_CMD, CMD_RAM_YCNT);
      add_word(yt);
    endfunction

    function void build_sleep();
      if (powered) begin
        add_item(KIND_CMD, CMD_UPD_CTRL1);
        add_item(KIND_DAT, DAT_CTRL1_NORM);
        add_item(KIND_CMD, CMD_UPD_CTRL2);
        add_item(KIND_DAT, DM_POWER_OFF);
        add_item(KIND_CMD, CMD_MASTER_ACT);
        add_item(KIND_WAIT, 8'h00);
        powered = 1'b0;
      end
      add_item(KIND_CMD, CMD_SLEEP);
      add_item(KIND_DAT, DAT_SLEEP);
    endfunction

    function void predict_script(in_req_t r);
      logic [1:0] m, used;
      m = (r.refresh_mode == MODE_BAD) ? MODE_FULL : r.refresh_mode;
      used = MODE_FULL;
      script.delete();
      case (r.func)
        FUNC_REFRESH: begin
          // display refresh: first paint goes full, cold start with no full override goes half
          if (r.from_display && !r.power_off_after) begin
            if (first_paint) begin
              m = MODE_FULL;
              first_paint = 1'b0;
            end else if (!powered && full_seq == 8'h00) begin
              m = MODE_HALF;
            end
          end
          used = m;
          build_refresh(m, r.power_off_after, r.lut_loaded);
        end
        FUNC_WINDOW: build_window(r.win_x, r.win_y, r.win_w, r.win_h);
        FUNC_SLEEP:  build_sleep();
        default: return;
      endcase
      foreach (script[i]) script[i].mode_used = used;
      script[script.size()-1].last = 1'b1;
      foreach (script[i]) expected_items.push_back(script[i]);
    endfunction

    task report(string msg);
      if (errors < REPORT_CAP) $display("[%0t] %s", $time, msg);
      errors++;
    endtask

    task check_item(out_item_t got);
      out_item_t want;
      if (expected_items.size() == 0) begin
        report($sformatf("item with nothing pending: kind=%0d byte=%02h",
                         got.kind, got.out_byte));
        return;
      end
      want = expected_items.pop_front();
      if (got.kind !== want.kind)
        report($sformatf("kind %0d, want %0d", got.kind, want.kind));
      if (got.out_byte !== want.out_byte)
        report($sformatf("byte %02h, want %02h", got.out_byte, want.out_byte));
      if (got.last !== want.last)
        report($sformatf("last %0b, want %0b (byte %02h)", got.last, want.last,
                         want.out_byte));
      if (got.mode_used !== want.mode_used)
        report($sformatf("mode_used %0d, want %0d", got.mode_used, want.mode_used));
    endtask
  endclass

endpackage

@@ tb/sv/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import eprs_pkg::*;
  import eprs_tb_pkg::*;

  // Generous watchdog; the slowest legal run is far below this.
  localparam int CYCLE_LIMIT = 1_000_000;
  // Quiet cycles after the last item before touching config or ending,
  // covers a request that is still being stepped through with no output.
  localparam int SETTLE = 30;
  localparam int PHASE_ITEMS = 65;

  logic                clk;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  in_req_t             in_data   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  out_item_t           out_data;
  logic                cfg_we    = 1'b0;
  logic [CFG_AW-1:0]   cfg_addr  = '0;
  logic [CFG_DW-1:0]   cfg_wdata = '0;

  int unsigned         cycles = 0;
  int                  ready_style = 0;
  int                  style_left = 0;
  logic [CFG_DW-1:0]   reg_plan [8];

  panel_script_board   sb = new;

  epaper_refresh_sequencer_core #(
    .PANEL_HEIGHT(PANEL_ROWS)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) cycles <= cycles + 1;

  // Watchdog: a hung handshake or a lost item ends here.
  initial begin
    wait (cycles >= CYCLE_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Monitor. Inputs change only by NBA at the edge, so the values seen here
  // are the ones the block sampled on this same edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.predict_script(in_data);
      if (out_valid && out_ready) sb.check_item(out_data);
    end
  end

  // Receiver backpressure: switches at random between styles so that stalls land
  // on every slot of a script, with full-speed stretches too.
  always @(posedge clk) begin
    if (style_left == 0) begin
      ready_style = $urandom_range(0, 3);
      style_left  = $urandom_range(20, 200);
    end
    style_left = style_left - 1;
    case (ready_style)
      0:       out_ready <= 1'b1;
      1:       out_ready <= ($urandom_range(0, 3) != 0);
      2:       out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= ~out_ready;
    endcase
  end

  function automatic in_req_t make_request(logic [1:0] f, logic [1:0] m, logic off,
                                           logic lut, logic disp, logic [9:0] x,
                                           logic [8:0] y, logic [9:0] w, logic [8:0] h);
    in_req_t r;
    r.func = f;
    r.refresh_mode = m;
    r.power_off_after = off;
    r.lut_loaded = lut;
    r.from_display = disp;
    r.win_x = x;
    r.win_y = y;
    r.win_w = w;
    r.win_h = h;
    return r;
  endfunction

  // Mostly refresh and window requests; some junk kinds and modes mixed in.
  // Windows are usually on the panel, sometimes arbitrary bit patterns.
  function automatic in_req_t random_request();
    in_req_t r;
    int pick;
    pick = $urandom_range(0, 99);
    r.func = (pick < 45) ? FUNC_REFRESH : (pick < 70) ? FUNC_WINDOW :
             (pick < 92) ? FUNC_SLEEP : FUNC_NONE;
    r.refresh_mode = ($urandom_range(0, 9) == 0) ? MODE_BAD : 2'($urandom_range(0, 2));
    r.power_off_after = ($urandom_range(0, 3) == 0);
    r.lut_loaded = ($urandom_range(0, 3) == 0);
    r.from_display = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 4) == 0) begin
      r.win_x = 10'($urandom);
      r.win_y = 9'($urandom);
      r.win_w = 10'($urandom);
      r.win_h = 9'($urandom);
    end else begin
      r.win_x = 10'($urandom_range(0, 799));
      r.win_y = 9'($urandom_range(0, 479));
      r.win_w = 10'($urandom_range(1, 800 - r.win_x));
      r.win_h = 9'($urandom_range(1, 480 - r.win_y));
    end
    return r;
  endfunction

  function automatic logic [CFG_DW-1:0] pick_reg_value();
    case ($urandom_range(0, 3))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // Holds valid with the request until the block takes it. Valid is left
  // high so back-to-back requests need no extra NBA in the same step.
  task automatic send_request(in_req_t r);
    in_data  <= r;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic pause_sender(int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Stop sending until every predicted item is out, then let the block settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Writes every register from reg_plan; only called with the block idle.
  task automatic program_regs();
    for (int i = 0; i < 8; i++) begin
      cfg_we    <= 1'b1;
      cfg_addr  <= CFG_AW'(i);
      cfg_wdata <= reg_plan[i];
      @(posedge clk);
      sb.set_reg(CFG_AW'(i), reg_plan[i]);
    end
    cfg_we <= 1'b0;
  endtask

  // Random requests in bursts; ignored request kinds do not count.
  task automatic send_batch(int count, bit with_gaps);
    in_req_t r;
    int left, burst;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 12);
      while (burst > 0 && left > 0) begin
        r = random_request();
        send_request(r);
        if (r.func != FUNC_NONE) left--;
        burst--;
      end
      if (with_gaps && $urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 10));
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed, reset config. First display refresh gets forced to full.
    send_request(make_request(FUNC_REFRESH, MODE_FAST, 0, 0, 1, 0, 0, 1, 1));
    send_request(make_request(FUNC_REFRESH, MODE_HALF, 0, 0, 0, 0, 0, 1, 1));
    send_request(make_request(FUNC_REFRESH, MODE_FAST, 0, 0, 0, 0, 0, 1, 1));
    // unused mode acts as full
    send_request(make_request(FUNC_REFRESH, MODE_BAD, 0, 0, 0, 0, 0, 1, 1));
    // loaded LUT forces the assembled control byte
    send_request(make_request(FUNC_REFRESH, MODE_FAST, 0, 1, 0, 0, 0, 1, 1));
    // power-off on a display refresh: no forcing
    send_request(make_request(FUNC_REFRESH, MODE_HALF, 1, 1, 1, 0, 0, 1, 1));
    send_request(make_request(FUNC_WINDOW, MODE_FULL, 0, 0, 0, 0, 0, 800, 480));
    // window off the panel and a zero-size window both wrap
    send_request(make_request(FUNC_WINDOW, MODE_FULL, 0, 0, 0, 1023, 511, 1023, 511));
    send_request(make_request(FUNC_WINDOW, MODE_FULL, 0, 0, 0, 799, 479, 0, 0));
    // unused request kind produces nothing
    send_request(make_request(FUNC_NONE, MODE_BAD, 1, 1, 1, 1023, 511, 1023, 511));
    send_request(make_request(FUNC_SLEEP, MODE_FULL, 0, 0, 0, 0, 0, 1, 1));
    send_request(make_request(FUNC_SLEEP, MODE_FULL, 0, 0, 0, 0, 0, 1, 1));
    drain();

    // No full or half overrides, no borders, mirrored columns: cold-start forcing to half.
    reg_plan[CFG_FULL_SEQ]    = 8'h00;
    reg_plan[CFG_FAST_SEQ]    = 8'hFF;
    reg_plan[CFG_HALF_SEQ]    = 8'h00;
    reg_plan[CFG_BORDER_FULL] = 8'h00;
    reg_plan[CFG_BORDER_FAST] = 8'h00;
    reg_plan[CFG_BORDER_HALF] = 8'h00;
    reg_plan[CFG_HALF_TEMP]   = 8'hFF;
    reg_plan[CFG_MIRROR]      = 8'h01;
    program_regs();
    send_request(make_request(FUNC_REFRESH, MODE_FAST, 0, 0, 1, 0, 0, 1, 1));
    send_request(make_request(FUNC_REFRESH, MODE_FAST, 1, 0, 1, 0, 0, 1, 1));
    send_request(make_request(FUNC_WINDOW, MODE_FULL, 0, 0, 0, 5, 7, 10, 3));
    send_request(make_request(FUNC_REFRESH, MODE_FULL, 0, 0, 0, 0, 0, 1, 1));
    send_request(make_request(FUNC_REFRESH, MODE_HALF, 0, 0, 0, 0, 0, 1, 1));
    send_request(make_request(FUNC_SLEEP, MODE_FULL, 0, 0, 0, 0, 0, 1, 1));
    send_request(make_request(FUNC_REFRESH, MODE_FAST, 0, 1, 0, 0, 0, 1, 1));
    drain();

    // Half falls back to full override and full border; fast is assembled.
    reg_plan[CFG_FULL_SEQ]    = 8'h01;
    reg_plan[CFG_FAST_SEQ]    = 8'h00;
    reg_plan[CFG_HALF_SEQ]    = 8'h00;
    reg_plan[CFG_BORDER_FULL] = 8'h55;
    reg_plan[CFG_BORDER_FAST] = 8'hAA;
    reg_plan[CFG_BORDER_HALF] = 8'h00;
    reg_plan[CFG_HALF_TEMP]   = 8'h00;
    reg_plan[CFG_MIRROR]      = 8'h00;
    program_regs();
    send_request(make_request(FUNC_REFRESH, MODE_HALF, 0, 0, 0, 0, 0, 1, 1));
    send_request(make_request(FUNC_REFRESH, MODE_FAST, 0, 0, 0, 0, 0, 1, 1));
    send_request(make_request(FUNC_REFRESH, MODE_FULL, 1, 0, 0, 0, 0, 1, 1));
    send_request(make_request(FUNC_WINDOW, MODE_FULL, 0, 0, 0, 0, 0, 800, 480));

    // Random phases: all-zero config, all-ones config, then mixed. Each
    // phase starts from a fully drained block; some phases run without gaps.
    for (int p = 0; p < 6; p++) begin
      drain();
      foreach (reg_plan[i])
        reg_plan[i] = (p == 0) ? 8'h00 : (p == 1) ? 8'hFF : pick_reg_value();
      program_regs();
      send_batch(PHASE_ITEMS, (p % 3) != 2);
    end
    drain();

    if (sb.pending() != 0) sb.report($sformatf("%0d items never came", sb.pending()));
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ epaper_refresh_sequencer_core.f @@
hw/rtl/eprs_pkg.sv
hw/rtl/eprs_ctrl.sv
hw/rtl/eprs_datapath.sv
hw/rtl/epaper_refresh_sequencer_core.sv
hw/rtl/eprs_checker.sv
tb/sv/eprs_tb_pkg.sv
tb/sv/tb.sv
